>>> rtl/signed_int_to_radix_text_defines.svh
// assertion macros shared by the radix text converter
`ifndef SIGNED_INT_TO_RADIX_TEXT_DEFINES_SVH
`define SIGNED_INT_TO_RADIX_TEXT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SIRT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sirt assertion failed");
// next-cycle implication
`define SIRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sirt assertion failed");
`else
`define SIRT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SIRT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/sirt_pkg.sv
// shared constants and controller/datapath interface types
`timescale 1ns / 1ps
package sirt_pkg;

   localparam int ALPHABET_DEPTH = 64;
   localparam int NUMBER_WIDTH = 32;
   localparam int DIGIT_INDEX_WIDTH = 6;
   localparam int SYMBOL_WIDTH = 8;
   localparam int RADIX_WIDTH = 7;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 2;

   localparam int DIGIT_WIDTH = $clog2(ALPHABET_DEPTH);
   localparam int MAX_DIGITS = NUMBER_WIDTH;
   localparam int BUF_ADDR_WIDTH = $clog2(MAX_DIGITS);
   localparam int COUNT_WIDTH = $clog2(MAX_DIGITS + 1);
   localparam int DIV_BITS = 4;
   localparam int DIV_STEPS = NUMBER_WIDTH / DIV_BITS;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);
   localparam int SEEN_IDX_WIDTH = SYMBOL_WIDTH - 1;
   localparam int SEEN_WIDTH = 2 ** SEEN_IDX_WIDTH;

   localparam logic [SYMBOL_WIDTH-1:0] SYM_LOW = 8'd32;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_END = 8'd127;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_PLUS = 8'h2B;
   localparam logic [SYMBOL_WIDTH-1:0] SYM_MINUS = 8'h2D;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_CONVERT = 1'b1;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_RADIX_ADDR = 2'd0;

   typedef struct packed {
      logic mem_wr;
      logic start;
      logic val_read;
      logic seen_set;
      logic div_step;
      logic dig_read;
      logic out_minus;
      logic out_sym;
   } cmd_type;

   typedef struct packed {
      logic radix_bad;
      logic sym_bad;
      logic val_last;
      logic div_last;
      logic quot_zero;
      logic neg;
      logic digits_done;
      logic out_busy;
      logic [COUNT_WIDTH-1:0] digit_count;
   } status_type;

endpackage

>>> rtl/signed_int_to_radix_text.sv
// channel    | handshake            | payload
// req        | req_valid/req_ready  | req_type, req_digit_index, req_digit_symbol, req_number_value
// rsp        | rsp_valid/rsp_ready  | rsp_out_char, rsp_last_char
// csr        | apb psel/penable     | radix_length at byte address 0
//
// a load request writes one alphabet entry and leaves the block idle; a convert request
// with radix below 2 or above 64 is dropped and also leaves it idle. otherwise the
// alphabet check reads one entry at a time through the single memory read port, and
// each digit comes out of the 4-bit-per-cycle restoring divider.
// reset is synchronous and active high; alphabet contents are kept, radix clears to 0.
// a stalled rsp holds the output register; the block waits with the next character.
`timescale 1ns / 1ps
`include "signed_int_to_radix_text_defines.svh"
module signed_int_to_radix_text (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic                                        req_type,
   input  logic [sirt_pkg::DIGIT_INDEX_WIDTH-1:0]      req_digit_index,
   input  logic [sirt_pkg::SYMBOL_WIDTH-1:0]           req_digit_symbol,
   input  logic signed [sirt_pkg::NUMBER_WIDTH-1:0]    req_number_value,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic [sirt_pkg::SYMBOL_WIDTH-1:0]           rsp_out_char,
   output logic                                        rsp_last_char,
   input  logic                                        csr_psel,
   input  logic                                        csr_penable,
   input  logic                                        csr_pwrite,
   input  logic [sirt_pkg::CSR_ADDR_WIDTH-1:0]         csr_paddr,
   input  logic [sirt_pkg::CSR_DATA_WIDTH-1:0]         csr_pwdata,
   output logic [sirt_pkg::CSR_DATA_WIDTH-1:0]         csr_prdata,
   output logic                                        csr_pready
);
   import sirt_pkg::*;

   cmd_type                dp_cmd;
   status_type             dp_status;
   logic [RADIX_WIDTH-1:0] radix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr == CSR_RADIX_ADDR)) begin
         radix_ff <= csr_pwdata[RADIX_WIDTH-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_RADIX_ADDR) ? CSR_DATA_WIDTH'(radix_ff) : '0;

   sirt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   sirt_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .status           (dp_status),
      .radix_length     (radix_ff),
      .req_digit_index  (req_digit_index),
      .req_digit_symbol (req_digit_symbol),
      .req_number_value (req_number_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_char     (rsp_out_char),
      .rsp_last_char    (rsp_last_char)
   );

   // load requests and rejected conversions leave the block idle
   `SIRT_ASSERT_NEXT(a_load_stays_idle, clock, reset, req_valid && req_ready && (req_type == REQ_LOAD), req_ready)
   `SIRT_ASSERT_NEXT(a_bad_radix_dropped, clock, reset, req_valid && req_ready && (req_type == REQ_CONVERT) && dp_status.radix_bad, req_ready)
   `SIRT_ASSERT_NEXT(a_convert_goes_busy, clock, reset, req_valid && req_ready && (req_type == REQ_CONVERT) && !dp_status.radix_bad, !req_ready)
   // never overwrite a character still waiting on the rsp side
   `SIRT_ASSERT_IMPL(a_no_output_overrun, clock, reset, dp_cmd.out_minus || dp_cmd.out_sym, !dp_status.out_busy)
   `SIRT_ASSERT_IMPL(a_digit_stack_bound, clock, reset, 1'b1, dp_status.digit_count <= COUNT_WIDTH'(MAX_DIGITS))

endmodule

>>> rtl/sirt_ctrl.sv
// sequencing state machine for alphabet check, division and text output
`timescale 1ns / 1ps
module sirt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_type,
   output logic                req_ready,
   input  sirt_pkg::status_type status,
   output sirt_pkg::cmd_type    cmd
);
   import sirt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VREAD,
      ST_VCHK,
      ST_DIV,
      ST_DIV_CHK,
      ST_SIGN,
      ST_RD,
      ST_PUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_type == REQ_LOAD) begin
                  cmd.mem_wr = 1'b1;
               end else if (!status.radix_bad) begin
                  cmd.start = 1'b1;
                  state_in = ST_VREAD;
               end
            end
         end
         ST_VREAD: begin
            cmd.val_read = 1'b1;
            state_in = ST_VCHK;
         end
         ST_VCHK: begin
            if (status.sym_bad) begin
               state_in = ST_IDLE;
            end else begin
               cmd.seen_set = 1'b1;
               state_in = status.val_last ? ST_DIV : ST_VREAD;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DIV_CHK;
            end
         end
         ST_DIV_CHK: begin
            state_in = status.quot_zero ? ST_SIGN : ST_DIV;
         end
         ST_SIGN: begin
            if (!status.neg) begin
               state_in = ST_RD;
            end else if (!status.out_busy) begin
               cmd.out_minus = 1'b1;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            cmd.dig_read = 1'b1;
            state_in = ST_PUT;
         end
         ST_PUT: begin
            if (!status.out_busy) begin
               cmd.out_sym = 1'b1;
               state_in = status.digits_done ? ST_IDLE : ST_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_ready = ready_ff;

endmodule

>>> rtl/sirt_dp.sv
// alphabet memory, symbol checker, radix divider, digit stack and output register
`timescale 1ns / 1ps
module sirt_dp (
   input  logic                                        clock,
   input  logic                                        reset,
   input  sirt_pkg::cmd_type                           cmd,
   output sirt_pkg::status_type                        status,
   input  logic [sirt_pkg::RADIX_WIDTH-1:0]            radix_length,
   input  logic [sirt_pkg::DIGIT_INDEX_WIDTH-1:0]      req_digit_index,
   input  logic [sirt_pkg::SYMBOL_WIDTH-1:0]           req_digit_symbol,
   input  logic signed [sirt_pkg::NUMBER_WIDTH-1:0]    req_number_value,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic [sirt_pkg::SYMBOL_WIDTH-1:0]           rsp_out_char,
   output logic                                        rsp_last_char
);
   import sirt_pkg::*;

   logic [SYMBOL_WIDTH-1:0]   alphabet_mem [ALPHABET_DEPTH];
   logic [SYMBOL_WIDTH-1:0]   rd_data_ff;
   logic [DIGIT_WIDTH-1:0]    rd_addr;
   logic [DIGIT_WIDTH-1:0]    idx_ff;
   logic [SEEN_WIDTH-1:0]     seen_ff;
   logic [NUMBER_WIDTH-1:0]   mag_ff;
   logic [NUMBER_WIDTH-1:0]   num_raw;
   logic                      neg_ff;
   logic [DIGIT_WIDTH-1:0]    rem_ff;
   logic [DIV_CNT_WIDTH-1:0]  cnt_ff;
   logic [DIGIT_WIDTH-1:0]    digit_buf_ff [MAX_DIGITS];
   logic [COUNT_WIDTH-1:0]    count_ff;
   logic [COUNT_WIDTH-1:0]    count_dec;
   logic [BUF_ADDR_WIDTH-1:0] top_idx;
   logic [NUMBER_WIDTH-1:0]   q_next;
   logic [DIGIT_WIDTH-1:0]    r_next;
   logic                      div_last;
   logic                      out_valid_ff;
   logic [SYMBOL_WIDTH-1:0]   out_char_ff;
   logic                      out_last_ff;

   assign num_raw   = $unsigned(req_number_value);
   assign count_dec = count_ff - COUNT_WIDTH'(1);
   assign top_idx   = count_dec[BUF_ADDR_WIDTH-1:0];
   assign rd_addr   = cmd.dig_read ? digit_buf_ff[top_idx] : idx_ff;
   assign div_last  = (cnt_ff == DIV_CNT_WIDTH'(DIV_STEPS - 1));

   // DIV_BITS restoring-division bits per cycle, remainder stays below the radix
   always_comb begin
      logic [DIGIT_WIDTH:0]    trial;
      logic [DIGIT_WIDTH-1:0]  r;
      logic [NUMBER_WIDTH-1:0] q;
      r = rem_ff;
      q = mag_ff;
      trial = '0;
      for (int k = 0; k < DIV_BITS; k++) begin
         trial = {r, q[NUMBER_WIDTH-1]};
         q = {q[NUMBER_WIDTH-2:0], 1'b0};
         if (trial >= radix_length) begin
            trial = trial - radix_length;
            q[0] = 1'b1;
         end
         r = trial[DIGIT_WIDTH-1:0];
      end
      q_next = q;
      r_next = r;
   end

   // alphabet store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.mem_wr && (32'(req_digit_index) < ALPHABET_DEPTH)) begin
         alphabet_mem[req_digit_index[DIGIT_WIDTH-1:0]] <= req_digit_symbol;
      end
      if (cmd.val_read || cmd.dig_read) begin
         rd_data_ff <= alphabet_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         idx_ff  <= '0;
         seen_ff <= '0;
         neg_ff  <= num_raw[NUMBER_WIDTH-1];
         mag_ff  <= num_raw[NUMBER_WIDTH-1] ? (NUMBER_WIDTH'(0) - num_raw) : num_raw;
         rem_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         if (cmd.seen_set) begin
            seen_ff[rd_data_ff[SEEN_IDX_WIDTH-1:0]] <= 1'b1;
            idx_ff <= idx_ff + DIGIT_WIDTH'(1);
         end
         if (cmd.div_step) begin
            mag_ff <= q_next;
            if (div_last) begin
               digit_buf_ff[count_ff[BUF_ADDR_WIDTH-1:0]] <= r_next;
               rem_ff <= '0;
               cnt_ff <= '0;
            end else begin
               rem_ff <= r_next;
               cnt_ff <= cnt_ff + DIV_CNT_WIDTH'(1);
            end
         end
      end
      if (cmd.out_minus || cmd.out_sym) begin
         out_char_ff <= cmd.out_minus ? SYM_MINUS : rd_data_ff;
         out_last_ff <= cmd.out_sym && (count_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            count_ff <= '0;
         end else if (cmd.div_step && div_last) begin
            count_ff <= count_ff + COUNT_WIDTH'(1);
         end else if (cmd.dig_read) begin
            count_ff <= count_dec;
         end
         if (cmd.out_minus || cmd.out_sym) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      status.radix_bad = (radix_length < RADIX_WIDTH'(2)) ||
                         (radix_length > RADIX_WIDTH'(ALPHABET_DEPTH));
      status.sym_bad = (rd_data_ff < SYM_LOW) || (rd_data_ff >= SYM_END) ||
                       (rd_data_ff == SYM_PLUS) || (rd_data_ff == SYM_MINUS) ||
                       seen_ff[rd_data_ff[SEEN_IDX_WIDTH-1:0]];
      status.val_last = ({1'b0, idx_ff} == (radix_length - RADIX_WIDTH'(1)));
      status.div_last = div_last;
      status.quot_zero = (mag_ff == '0);
      status.neg = neg_ff;
      status.digits_done = (count_ff == '0);
      status.out_busy = out_valid_ff;
      status.digit_count = count_ff;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_char  = out_char_ff;
   assign rsp_last_char = out_last_ff;

endmodule

>>> verif/testbench.sv
// self-checking testbench for the signed integer to radix text converter
`timescale 1ns / 1ps
module testbench;
   import sirt_pkg::*;

   localparam int CLOCK_HALF = 2;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int DRAIN_CYCLES = 400;
   localparam int IDLE_PCT = 15;
   localparam int RANDOM_REQUESTS = 360;
   localparam int HOLD_CYCLES = 3000;

   typedef struct packed {
      logic [SYMBOL_WIDTH-1:0] ch;
      logic                    last;
   } text_char_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic                                 req_type = REQ_LOAD;
   logic [DIGIT_INDEX_WIDTH-1:0]         req_digit_index = '0;
   logic [SYMBOL_WIDTH-1:0]              req_digit_symbol = '0;
   logic signed [NUMBER_WIDTH-1:0]       req_number_value = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic [SYMBOL_WIDTH-1:0]              rsp_out_char;
   logic                                 rsp_last_char;
   logic                                 csr_psel = 1'b0;
   logic                                 csr_penable = 1'b0;
   logic                                 csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0]            csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0]            csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0]            csr_prdata;
   logic                                 csr_pready;

   // shadow of the block state
   logic [SYMBOL_WIDTH-1:0] glyph_table [ALPHABET_DEPTH] = '{default: 8'h00};
   logic [RADIX_WIDTH-1:0]  radix_setting = '0;
   text_char_type           pending_chars [$];

   int fail_count = 0;
   int cycle_count = 0;
   int rsp_hold_left = 0;
   int requests_sent = 0;
   bit idle_off = 1'b0;

   signed_int_to_radix_text u_top (.*);

   always #(CLOCK_HALF) clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("signed_int_to_radix_text: mismatch");
         $finish;
      end
   end

   function automatic bit symbol_ok(input logic [SYMBOL_WIDTH-1:0] s);
      return s >= SYM_LOW && s < SYM_END && s != SYM_PLUS && s != SYM_MINUS;
   endfunction

   function automatic bit symbol_in_use(input logic [SYMBOL_WIDTH-1:0] s);
      foreach (glyph_table[i])
         if (glyph_table[i] == s) return 1'b1;
      return 1'b0;
   endfunction

   function automatic bit alphabet_usable(input int base);
      bit seen [256];
      if (base < 2 || base > ALPHABET_DEPTH) return 1'b0;
      for (int i = 0; i < base; i++) begin
         if (!symbol_ok(glyph_table[i]) || seen[glyph_table[i]]) return 1'b0;
         seen[glyph_table[i]] = 1'b1;
      end
      return 1'b1;
   endfunction

   // applies one accepted request and queues the characters it produces
   function automatic void predict_text(input logic kind,
                                        input logic [DIGIT_INDEX_WIDTH-1:0] idx,
                                        input logic [SYMBOL_WIDTH-1:0] sym,
                                        input logic signed [NUMBER_WIDTH-1:0] val);
      logic [NUMBER_WIDTH-1:0] mag;
      logic [SYMBOL_WIDTH-1:0] digits [$];
      text_char_type           c;
      int                      base;
      base = radix_setting;
      if (kind == REQ_LOAD) begin
         glyph_table[idx] = sym;
         return;
      end
      if (!alphabet_usable(base)) return;
      mag = val;
      if (val[NUMBER_WIDTH-1]) mag = ~mag + 1'b1;
      do begin
         digits.push_front(glyph_table[mag % base]);
         mag = mag / base;
      end while (mag != 0);
      if (val[NUMBER_WIDTH-1]) begin
         c.ch = SYM_MINUS;
         c.last = 1'b0;
         pending_chars.push_back(c);
      end
      foreach (digits[i]) begin
         c.ch = digits[i];
         c.last = (i == digits.size() - 1);
         pending_chars.push_back(c);
      end
   endfunction

   function automatic logic [SYMBOL_WIDTH-1:0] fresh_symbol();
      logic [SYMBOL_WIDTH-1:0] s;
      do s = SYMBOL_WIDTH'($urandom_range(SYM_LOW, SYM_END - 1));
      while (!symbol_ok(s) || symbol_in_use(s));
      return s;
   endfunction

   function automatic logic signed [NUMBER_WIDTH-1:0] pick_number(input int base);
      int                             pick;
      logic signed [NUMBER_WIDTH-1:0] v;
      pick = $urandom_range(99);
      if (pick < 10) begin
         case ($urandom_range(4))
            0: v = 0;
            1: v = 1;
            2: v = -1;
            3: v = 32'sh7FFF_FFFF;
            default: v = 32'sh8000_0000;
         endcase
      end else if (pick < 40) begin
         v = $urandom_range(0, base * base + base);
         if ($urandom_range(1)) v = -v;
      end else
         v = $urandom;
      return v;
   endfunction

   // response side: check each accepted char, then pick next ready
   always @(posedge clock) begin
      text_char_type want;
      if (rsp_valid && rsp_ready) begin
         if (pending_chars.size() == 0) begin
            fail_count++;
            $display("%0t: expected no char, got %h last %b", $time, rsp_out_char,
                     rsp_last_char);
         end else begin
            want = pending_chars.pop_front();
            if (rsp_out_char !== want.ch) begin
               fail_count++;
               $display("%0t: out_char expected %h, got %h", $time, want.ch, rsp_out_char);
            end
            if (rsp_last_char !== want.last) begin
               fail_count++;
               $display("%0t: last_char expected %b, got %b", $time, want.last,
                        rsp_last_char);
            end
         end
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else
         rsp_ready <= idle_off || $urandom_range(99) >= IDLE_PCT;
   end

   task automatic send_request(input logic kind,
                               input logic [DIGIT_INDEX_WIDTH-1:0] idx,
                               input logic [SYMBOL_WIDTH-1:0] sym,
                               input logic signed [NUMBER_WIDTH-1:0] val);
      int gap;
      req_valid <= 1'b1;
      req_type <= kind;
      req_digit_index <= idx;
      req_digit_symbol <= sym;
      req_number_value <= val;
      do @(posedge clock); while (!req_ready);
      predict_text(kind, idx, sym, val);
      requests_sent++;
      // valid stays high only when the next request follows at once
      gap = (!idle_off && $urandom_range(99) < IDLE_PCT) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic load_glyph(input int idx, input logic [SYMBOL_WIDTH-1:0] sym);
      send_request(REQ_LOAD, DIGIT_INDEX_WIDTH'(idx), sym, NUMBER_WIDTH'($urandom));
   endtask

   task automatic convert_number(input logic signed [NUMBER_WIDTH-1:0] val);
      send_request(REQ_CONVERT, DIGIT_INDEX_WIDTH'($urandom), SYMBOL_WIDTH'($urandom), val);
   endtask

   // stop requests, wait for every expected char, then let the block go idle
   task automatic drain_text();
      req_valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_radix(input int value);
      drain_text();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_RADIX_ADDR;
      csr_pwdata <= CSR_DATA_WIDTH'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      radix_setting = RADIX_WIDTH'(value);
      // read back
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_WIDTH'(radix_setting)) begin
         fail_count++;
         $display("%0t: radix readback expected %h, got %h", $time,
                  CSR_DATA_WIDTH'(radix_setting), csr_prdata);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // rewrite every entry that is out of range or repeats an earlier one
   task automatic repair_alphabet();
      bit seen [256];
      for (int i = 0; i < ALPHABET_DEPTH; i++) begin
         if (!symbol_ok(glyph_table[i]) || seen[glyph_table[i]])
            load_glyph(i, fresh_symbol());
         seen[glyph_table[i]] = 1'b1;
      end
   endtask

   // radix outside 2..64 drops the request without touching the alphabet
   task automatic test_radix_limits();
      convert_number(5);
      set_radix(1);
      convert_number(-5);
      set_radix(127);
      convert_number(12);
      set_radix(65);
      convert_number(-1);
   endtask

   task automatic test_decimal_text();
      for (int i = 0; i < 10; i++) load_glyph(i, SYMBOL_WIDTH'("0" + i));
      set_radix(10);
      convert_number(0);
      convert_number(-1);
      convert_number(32'sh7FFF_FFFF);
      convert_number(32'sh8000_0000);
   endtask

   task automatic test_binary_text();
      set_radix(2);
      convert_number(32'sh8000_0000);
   endtask

   task automatic test_bad_alphabet();
      load_glyph(1, SYM_PLUS);
      convert_number(3);
      load_glyph(1, SYM_MINUS);
      convert_number(3);
      load_glyph(1, SYM_LOW - 8'd1);
      convert_number(3);
      load_glyph(1, SYM_END);
      convert_number(3);
      // repeated symbol
      load_glyph(1, "0");
      convert_number(3);
      // lowest and highest legal symbols
      load_glyph(1, SYM_LOW);
      load_glyph(0, SYM_END - 8'd1);
      convert_number(-2);
      load_glyph(ALPHABET_DEPTH - 1, 8'hFF);
   endtask

   task automatic test_random_text();
      int target;
      int base;
      int pick;
      target = requests_sent + RANDOM_REQUESTS;
      while (requests_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 5) base = $urandom_range(0, 1);
         else if (pick < 9) base = $urandom_range(ALPHABET_DEPTH + 1, 127);
         else if (pick < 20) base = ALPHABET_DEPTH;
         else if (pick < 28) base = 2;
         else base = $urandom_range(2, ALPHABET_DEPTH);
         set_radix(base);
         repair_alphabet();
         repeat ($urandom_range(10, 25)) begin
            pick = $urandom_range(99);
            if (pick < 70) convert_number(pick_number(base));
            else if (pick < 88) load_glyph($urandom_range(0, ALPHABET_DEPTH - 1), fresh_symbol());
            else if (pick < 94)
               load_glyph($urandom_range(0, ALPHABET_DEPTH - 1), SYMBOL_WIDTH'($urandom));
            else
               load_glyph($urandom_range(0, ALPHABET_DEPTH - 1),
                          glyph_table[$urandom_range(0, ALPHABET_DEPTH - 1)]);
         end
      end
   endtask

   task automatic test_steady_stream();
      idle_off = 1'b1;
      set_radix(16);
      repair_alphabet();
      repeat (40) convert_number(pick_number(16));
      drain_text();
      idle_off = 1'b0;
   endtask

   // response side held off long enough for the block to stall its input
   task automatic test_backpressure();
      set_radix(2);
      repair_alphabet();
      rsp_hold_left = HOLD_CYCLES;
      repeat (12) convert_number($urandom | 32'h4000_0000);
      drain_text();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_radix_limits();
      test_decimal_text();
      test_binary_text();
      test_bad_alphabet();
      test_random_text();
      test_steady_stream();
      test_backpressure();
      drain_text();
      if (fail_count == 0)
         $display("signed_int_to_radix_text: match");
      else
         $display("signed_int_to_radix_text: mismatch");
      $finish;
   end

endmodule
